>>> rtl/dwsd_pkg.sv
// Shared types, codes and helpers for the DAQ word stream deframer.
package dwsd_pkg;

    // Result kinds
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_CHAN     = 3'd1;
    localparam logic [2:0] KIND_SAMPLE   = 3'd2;
    localparam logic [2:0] KIND_EVT_END  = 3'd3;
    localparam logic [2:0] KIND_BARRIER  = 3'd4;
    localparam logic [2:0] KIND_OVERLONG = 3'd5;
    localparam logic [2:0] KIND_BAD_FLAG = 3'd6;

    // Flag nibbles
    localparam logic [3:0] FLAG_ADC    = 4'h0;
    localparam logic [3:0] FLAG_CHAN   = 4'h4;
    localparam logic [3:0] FLAG_RESUME = 4'h5;
    localparam logic [3:0] FLAG_END    = 4'hE;

    localparam logic [15:0] BARRIER_WORD    = 16'hFFFF;
    localparam logic [15:0] MAX_SAMPLES_RST = 16'd50000;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One queue entry: every result one word causes (one or two)
    typedef struct packed {
        logic [2:0]  kind0;
        logic [2:0]  kind1;
        logic        two;
        logic [23:0] event_number;
        logic [23:0] run_number;
        logic [23:0] event_size;
        logic [11:0] channel;
        logic [11:0] sample;
        logic        last_sample;
        logic [3:0]  flag;
    } entry_t;

    // hi*4095 + lo, kept to 24 bits
    function automatic logic [23:0] combine(input logic [11:0] hi, input logic [11:0] lo);
        logic [23:0] acc;
        acc = {hi, 12'd0} - {12'd0, hi};
        return acc + {12'd0, lo};
    endfunction

endpackage

>>> rtl/daq_word_stream_deframer.sv
// Top level of the DAQ word stream deframer.
//
//  channel   direction  handshake            beat contents
//  input     in         in_valid / in_stall  word
//  output    out        out_valid / out_stall kind, event_number, run_number,
//                                            event_size, channel, sample,
//                                            last_sample, flag_seen, final_of_item
//  config    in         max_samples_we       max_samples
//
// A word is taken every cycle while the 4-entry queue has room; framing state
// updates in the same cycle. Each result leaves as its own output beat, so the
// output side sets the sustained rate. A result passes through the queue and
// the held-entry register of the back part. Reset clears framing state and
// sets max_samples to 50000. in_stall rises only when the queue is full.
module daq_word_stream_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] word,
    input  logic        max_samples_we,
    input  logic [15:0] max_samples,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [23:0] event_number,
    output logic [23:0] run_number,
    output logic [23:0] event_size,
    output logic [11:0] channel,
    output logic [11:0] sample,
    output logic        last_sample,
    output logic [3:0]  flag_seen,
    output logic        final_of_item
);

    dwsd_pkg::entry_t push_data;
    dwsd_pkg::entry_t pop_data;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;

    // Word classification and state
    dwsd_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .word           (word),
        .max_samples_we (max_samples_we),
        .max_samples    (max_samples),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (push_data)
    );

    // Decoupling queue
    dwsd_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .pop     (q_pop),
        .rd_data (pop_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Result output
    dwsd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .event_number  (event_number),
        .run_number    (run_number),
        .event_size    (event_size),
        .channel       (channel),
        .sample        (sample),
        .last_sample   (last_sample),
        .flag_seen     (flag_seen),
        .final_of_item (final_of_item)
    );

endmodule

>>> rtl/dwsd_front.sv
// Front part: takes each word, tracks framing state and builds result entries.
module dwsd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [15:0]          word,
    input  logic                 max_samples_we,
    input  logic [15:0]          max_samples,
    input  logic                 q_full,
    output logic                 q_push,
    output dwsd_pkg::entry_t     q_data
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SCAN   = 2'd1;
    localparam logic [1:0] PH_ADC    = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [11:0] size_hi_reg, size_hi_next;
    logic [11:0] num_hi_reg, num_hi_next;
    logic [11:0] run_hi_reg, run_hi_next;
    logic [23:0] evt_num_reg, evt_num_next;
    logic [23:0] run_num_reg, run_num_next;
    logic [23:0] evt_size_reg, evt_size_next;
    logic [15:0] count_reg, count_next;
    logic [11:0] chan_reg, chan_next;
    logic [15:0] max_reg;

    logic        fire;
    logic [3:0]  flag;
    logic [11:0] data;
    logic        push;
    logic [2:0]  k0, k1;
    logic        two;
    logic [11:0] smp;
    logic        last;

    assign in_stall = q_full;
    assign fire     = in_valid & ~q_full;
    assign flag     = word[15:12];
    assign data     = word[11:0];

    // Next-state and result decode for one word
    always_comb
    begin
        phase_next    = phase_reg;
        hidx_next     = hidx_reg;
        size_hi_next  = size_hi_reg;
        num_hi_next   = num_hi_reg;
        run_hi_next   = run_hi_reg;
        evt_num_next  = evt_num_reg;
        run_num_next  = run_num_reg;
        evt_size_next = evt_size_reg;
        count_next    = count_reg;
        chan_next     = chan_reg;
        push          = 1'b0;
        k0            = dwsd_pkg::KIND_HEADER;
        k1            = dwsd_pkg::KIND_HEADER;
        two           = 1'b0;
        smp           = 12'd0;
        last          = 1'b0;

        unique case (phase_reg)
            PH_SCAN:
            begin
                if (flag == dwsd_pkg::FLAG_CHAN)
                begin
                    chan_next  = data;
                    count_next = 16'd0;
                    phase_next = PH_ADC;
                    push       = 1'b1;
                    k0         = dwsd_pkg::KIND_CHAN;
                end
                else if (flag == dwsd_pkg::FLAG_END)
                begin
                    phase_next = PH_HEADER;
                    hidx_next  = 4'd0;
                    push       = 1'b1;
                    k0         = dwsd_pkg::KIND_EVT_END;
                end
                else if (flag != dwsd_pkg::FLAG_ADC)
                begin
                    push = 1'b1;
                    k0   = dwsd_pkg::KIND_BAD_FLAG;
                end
            end
            PH_ADC:
            begin
                push = 1'b1;
                if (count_reg >= max_reg)
                begin
                    phase_next = PH_HEADER;
                    hidx_next  = 4'd0;
                    count_next = 16'd0;
                    k0         = dwsd_pkg::KIND_OVERLONG;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                    k0         = dwsd_pkg::KIND_SAMPLE;
                    smp        = data;
                    last       = (flag != dwsd_pkg::FLAG_ADC);
                    if (flag != dwsd_pkg::FLAG_ADC)
                    begin
                        phase_next = PH_SCAN;
                        if (flag == dwsd_pkg::FLAG_END)
                        begin
                            phase_next = PH_HEADER;
                            hidx_next  = 4'd0;
                            two        = 1'b1;
                            k1         = dwsd_pkg::KIND_EVT_END;
                        end
                        else if (flag != dwsd_pkg::FLAG_RESUME)
                        begin
                            two = 1'b1;
                            k1  = dwsd_pkg::KIND_BAD_FLAG;
                        end
                    end
                end
            end
            default:
            begin
                // header phase, and the unused phase code
                phase_next = PH_HEADER;
                unique case (hidx_reg) inside
                    4'd0, 4'd1, 4'd2:
                    begin
                        if (word != dwsd_pkg::BARRIER_WORD)
                        begin
                            hidx_next = 4'd0;
                            push      = 1'b1;
                            k0        = dwsd_pkg::KIND_BARRIER;
                        end
                        else
                        begin
                            hidx_next = hidx_reg + 4'd1;
                        end
                    end
                    4'd4:
                    begin
                        size_hi_next = data;
                        hidx_next    = hidx_reg + 4'd1;
                    end
                    4'd5:
                    begin
                        evt_size_next = dwsd_pkg::combine(size_hi_reg, data);
                        hidx_next     = hidx_reg + 4'd1;
                    end
                    4'd6:
                    begin
                        num_hi_next = data;
                        hidx_next   = hidx_reg + 4'd1;
                    end
                    4'd7:
                    begin
                        evt_num_next = dwsd_pkg::combine(num_hi_reg, data);
                        hidx_next    = hidx_reg + 4'd1;
                    end
                    4'd8:
                    begin
                        run_hi_next = data;
                        hidx_next   = hidx_reg + 4'd1;
                    end
                    4'd9:
                    begin
                        run_num_next = dwsd_pkg::combine(run_hi_reg, data);
                        hidx_next    = hidx_reg + 4'd1;
                    end
                    4'd11:
                    begin
                        hidx_next  = 4'd0;
                        phase_next = PH_SCAN;
                        push       = 1'b1;
                        k0         = dwsd_pkg::KIND_HEADER;
                    end
                    4'd3, 4'd10:
                    begin
                        hidx_next = hidx_reg + 4'd1;
                    end
                    default:
                    begin
                        hidx_next = 4'd0;
                    end
                endcase
            end
        endcase
    end

    // Queue entry carries register values as they stand after this word
    always_comb
    begin
        q_data.kind0        = k0;
        q_data.kind1        = k1;
        q_data.two          = two;
        q_data.event_number = evt_num_next;
        q_data.run_number   = run_num_next;
        q_data.event_size   = evt_size_next;
        q_data.channel      = chan_next;
        q_data.sample       = smp;
        q_data.last_sample  = last;
        q_data.flag         = flag;
    end

    assign q_push = fire & push;

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hidx_reg     <= 4'd0;
            size_hi_reg  <= 12'd0;
            num_hi_reg   <= 12'd0;
            run_hi_reg   <= 12'd0;
            evt_num_reg  <= 24'd0;
            run_num_reg  <= 24'd0;
            evt_size_reg <= 24'd0;
            count_reg    <= 16'd0;
            chan_reg     <= 12'd0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            hidx_reg     <= hidx_next;
            size_hi_reg  <= size_hi_next;
            num_hi_reg   <= num_hi_next;
            run_hi_reg   <= run_hi_next;
            evt_num_reg  <= evt_num_next;
            run_num_reg  <= run_num_next;
            evt_size_reg <= evt_size_next;
            count_reg    <= count_next;
            chan_reg     <= chan_next;
        end
    end

    // Sample limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= dwsd_pkg::MAX_SAMPLES_RST;
        end
        else if (max_samples_we)
        begin
            max_reg <= max_samples;
        end
    end

endmodule

>>> rtl/dwsd_fifo.sv
// Short queue of result entries between the front and back parts.
module dwsd_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dwsd_pkg::entry_t     wr_data,
    input  logic                 pop,
    output dwsd_pkg::entry_t     rd_data,
    output logic                 full,
    output logic                 empty
);

    dwsd_pkg::entry_t                    mem_reg [dwsd_pkg::FIFO_DEPTH];
    logic [dwsd_pkg::FIFO_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [dwsd_pkg::FIFO_AW:0]          count_reg, count_next;

    assign full    = (count_reg == (dwsd_pkg::FIFO_AW+1)'(dwsd_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/dwsd_back.sv
// Back part: drains queue entries and hands out one result beat per cycle while out_stall is low.
module dwsd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  dwsd_pkg::entry_t     q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           kind,
    output logic [23:0]          event_number,
    output logic [23:0]          run_number,
    output logic [23:0]          event_size,
    output logic [11:0]          channel,
    output logic [11:0]          sample,
    output logic                 last_sample,
    output logic [3:0]           flag_seen,
    output logic                 final_of_item
);

    dwsd_pkg::entry_t cur_reg;
    logic             valid_reg;
    logic             sel_reg;
    logic             take;
    logic             last_of_entry;

    assign take          = valid_reg & ~out_stall;
    assign last_of_entry = sel_reg | ~cur_reg.two;
    assign q_pop         = ~q_empty & (~valid_reg | (take & last_of_entry));

    // Output view of the held entry; second result has no sample
    assign out_valid     = valid_reg;
    assign kind          = sel_reg ? cur_reg.kind1 : cur_reg.kind0;
    assign event_number  = cur_reg.event_number;
    assign run_number    = cur_reg.run_number;
    assign event_size    = cur_reg.event_size;
    assign channel       = cur_reg.channel;
    assign sample        = sel_reg ? 12'd0 : cur_reg.sample;
    assign last_sample   = sel_reg ? 1'b0 : cur_reg.last_sample;
    assign flag_seen     = cur_reg.flag;
    assign final_of_item = last_of_entry;

    // Output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            sel_reg   <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= ~last_of_entry;
            sel_reg   <= ~last_of_entry;
        end
    end

    // Held entry
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

endmodule
